FILE: src/brf_pkg.sv
// Package: transaction types, relocation codes and Thumb-2 imm16 helpers for the fixup core.
package brf_pkg;

    localparam int unsigned DeltaWidth = 64;

    localparam logic [3:0] RELOC_PAD         = 4'd0;
    localparam logic [3:0] RELOC_HIGHLOW     = 4'd3;
    localparam logic [3:0] RELOC_THUMB_MOV32 = 4'd7;
    localparam logic [3:0] RELOC_DIR64       = 4'd10;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_FIRST   = 2'd1;
    localparam logic [1:0] ACT_BOTH    = 2'd2;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [31:0] page_address;
        logic [15:0] reloc_entry;
        logic [31:0] word_first;
        logic [31:0] word_second;
    } reloc_in_t;

    typedef struct packed {
        logic [31:0] target_address;
        logic [31:0] new_first;
        logic [31:0] new_second;
        logic [1:0]  action;
    } reloc_out_t;

    // imm16 = imm4:i:imm3:imm8
    function automatic logic [15:0] thumb_imm16_get(input logic [31:0] insn);
        thumb_imm16_get = {insn[3:0], insn[10], insn[30:28], insn[23:16]};
    endfunction

    function automatic logic [31:0] thumb_imm16_put(input logic [31:0] insn,
                                                    input logic [15:0] imm16);
        logic [31:0] r;
        r        = insn;
        r[3:0]   = imm16[15:12];
        r[10]    = imm16[11];
        r[30:28] = imm16[10:8];
        r[23:16] = imm16[7:0];
        thumb_imm16_put = r;
    endfunction

endpackage

FILE: src/brf_fixup.sv
// Combinational fixup datapath: target address, patched words and action for one entry.
module brf_fixup (
    input  brf_pkg::reloc_in_t                  item,
    input  logic [brf_pkg::DeltaWidth-1:0]      delta,
    input  logic                                delta_nz,
    output brf_pkg::reloc_out_t                 result
);

    logic [3:0]  kind;
    logic [11:0] offset;
    logic [63:0] pair_sum;
    logic [31:0] word_sum;
    logic [31:0] thumb_sum;

    assign kind   = item.reloc_entry[15:12];
    assign offset = item.reloc_entry[11:0];

    assign pair_sum  = {item.word_second, item.word_first} + delta;
    assign word_sum  = item.word_first + delta[31:0];
    assign thumb_sum = {brf_pkg::thumb_imm16_get(item.word_second),
                        brf_pkg::thumb_imm16_get(item.word_first)} + delta[31:0];

    always_comb
    begin
        result.target_address = item.page_address + {20'd0, offset};
        result.new_first      = item.word_first;
        result.new_second     = item.word_second;
        result.action         = brf_pkg::ACT_NONE;
        if (delta_nz)
        begin
            unique case (kind)
                brf_pkg::RELOC_PAD:
                begin
                    result.action = brf_pkg::ACT_NONE;
                end
                brf_pkg::RELOC_HIGHLOW:
                begin
                    result.new_first = word_sum;
                    result.action    = brf_pkg::ACT_FIRST;
                end
                brf_pkg::RELOC_DIR64:
                begin
                    result.new_first  = pair_sum[31:0];
                    result.new_second = pair_sum[63:32];
                    result.action     = brf_pkg::ACT_BOTH;
                end
                brf_pkg::RELOC_THUMB_MOV32:
                begin
                    result.new_first  = brf_pkg::thumb_imm16_put(item.word_first,
                                                                 thumb_sum[15:0]);
                    result.new_second = brf_pkg::thumb_imm16_put(item.word_second,
                                                                 thumb_sum[31:16]);
                    result.action     = brf_pkg::ACT_BOTH;
                end
                default:
                begin
                    result.action = brf_pkg::ACT_UNKNOWN;
                end
            endcase
        end
    end

endmodule

FILE: src/base_relocation_fixup_core.sv
// Top level: base relocation fixup core with input and result registers and delta register.
//
// Applies one image base relocation entry per transaction. An accepted entry is held in an
// input register, patched by one pass of combinational logic (a 64-bit add is the longest
// path) and captured in a result register that drives out_valid; the core sustains one
// transaction per cycle while out_ready stays high. A full result register blocks input only
// while the input register is full too: that register keeps taking transactions while the
// result moves on. The user must write image_delta through cfg_we/cfg_data only while the
// core is idle (the core does not enforce it). A zero delta makes all entries, unknown types too, action 0.
module base_relocation_fixup_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  brf_pkg::reloc_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output brf_pkg::reloc_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [brf_pkg::DeltaWidth-1:0]      cfg_data
);

    logic [brf_pkg::DeltaWidth-1:0] delta_reg;
    logic                           delta_nz_reg;
    brf_pkg::reloc_in_t             in_item_reg;
    logic                           in_valid_reg;
    brf_pkg::reloc_out_t            out_item_reg;
    logic                           out_valid_reg;
    brf_pkg::reloc_out_t            fix_result;
    logic                           out_free;
    logic                           advance;
    logic                           in_take;
    logic                           in_valid_next;
    logic                           out_valid_next;

    assign out_free       = !out_valid_reg || out_ready;
    assign advance        = in_valid_reg && out_free;
    assign in_ready       = !in_valid_reg || out_free;
    assign in_take        = in_valid && in_ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg    <= '0;
            delta_nz_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            delta_reg    <= cfg_data;
            delta_nz_reg <= |cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= fix_result;
        end
    end

    brf_fixup u_fixup (
        .item     (in_item_reg),
        .delta    (delta_reg),
        .delta_nz (delta_nz_reg),
        .result   (fix_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_zero_delta_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !delta_nz_reg) |-> (out_item_reg.action == brf_pkg::ACT_NONE))
        else $error("action other than none with zero delta");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced transaction did not reach result register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input not ready with empty input register");

    a_delta_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (delta_nz_reg == ($past(cfg_data) != '0)))
        else $error("nonzero delta flag out of step with delta");

endmodule
